>>> hdl/qdec_pkg.sv
// Shared types and constants of the multi-channel quadrature decoder.
// No dependencies; imported by qdec_lane, qdec_merge and multi_quadrature_decoder.
package qdec_pkg;

    localparam int PHASE_WIDTH     = 8;
    localparam int FIELD_WIDTH     = 16;
    localparam int NUM_FIELDS      = 4;
    localparam int LIFE_WIDTH      = 8;
    localparam int COUNT_WIDTH     = 3;
    localparam int CFG_DATA_WIDTH  = 8;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_OFF_LIFE   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENCODERS_IN_USE = 2'd1;

    localparam logic [COUNT_WIDTH-1:0] ENCODERS_RESET = 3'd4;

    // Step codes: rank difference of new pair versus old pair, modulo 4.
    localparam logic [1:0] STEP_CW  = 2'd1;
    localparam logic [1:0] STEP_CCW = 2'd3;

    // Phase pair {B,A} to its place in the clockwise cycle 00 -> 01 -> 11 -> 10.
    localparam logic [1:0] GRAY_RANK [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

    // Per-lane control from the top level.
    typedef struct packed {
        logic fire;    // input transfer this cycle
        logic decode;  // lane is among the encoders in use
    } lane_ctrl_t;

endpackage

>>> hdl/multi_quadrature_decoder.sv
// Top level of the multi-channel quadrature decoder: config registers,
// phase history, decoder lanes and merge stage. Depends on qdec_pkg, qdec_lane, qdec_merge.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, phase_byte       | sink
//  out     | out_valid, out_stall, position_0..3  | source
//  cfg     | cfg_we, cfg_index, cfg_data          | sink
//
// One phase byte per cycle while in_stall is low; each result appears in the cycle after its
// transfer, as the lane updates feed the output register directly.
// Reset clears positions, hold-off counters, phase history and output valid.
// A stalled result holds; in_stall rises only while a result waits under out_stall.
module multi_quadrature_decoder #(
    parameter int MAX_ENCODERS   = 4,
    parameter int POSITION_WIDTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [qdec_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [qdec_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [qdec_pkg::PHASE_WIDTH-1:0]        phase_byte,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [qdec_pkg::FIELD_WIDTH-1:0]        position_0,
    output logic [qdec_pkg::FIELD_WIDTH-1:0]        position_1,
    output logic [qdec_pkg::FIELD_WIDTH-1:0]        position_2,
    output logic [qdec_pkg::FIELD_WIDTH-1:0]        position_3
);
    import qdec_pkg::*;

    logic [LIFE_WIDTH-1:0]  life_reg;
    logic [COUNT_WIDTH-1:0] encoders_reg;
    logic [PHASE_WIDTH-1:0] last_phases_reg;
    logic                   in_fire;
    logic                   busy;
    logic [POSITION_WIDTH-1:0] lane_pos      [MAX_ENCODERS];
    logic [POSITION_WIDTH-1:0] lane_pos_next [MAX_ENCODERS];
    logic [FIELD_WIDTH-1:0]    out_field     [NUM_FIELDS];

    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            life_reg     <= '0;
            encoders_reg <= ENCODERS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HOLD_OFF_LIFE:   life_reg     <= cfg_data[LIFE_WIDTH-1:0];
                REG_ENCODERS_IN_USE: encoders_reg <= cfg_data[COUNT_WIDTH-1:0];
                default:             ;  // unknown index ignored
            endcase
        end
    end

    // Whole byte kept, including pairs of encoders not in use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_phases_reg <= '0;
        else if (in_fire)
            last_phases_reg <= phase_byte;
    end

    for (genvar k = 0; k < MAX_ENCODERS; k++)
    begin : g_lane
        localparam logic [COUNT_WIDTH-1:0] LANE_ID = COUNT_WIDTH'(k);
        lane_ctrl_t ctrl;

        // counts above MAX_ENCODERS saturate for free: no lane beyond it exists
        assign ctrl.fire   = in_fire;
        assign ctrl.decode = encoders_reg > LANE_ID;

        qdec_lane #(
            .POSITION_WIDTH (POSITION_WIDTH)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .life        (life_reg),
            .pair_before (last_phases_reg[2*k +: 2]),
            .pair_after  (phase_byte[2*k +: 2]),
            .pos         (lane_pos[k]),
            .pos_next    (lane_pos_next[k])
        );
    end

    qdec_merge #(
        .MAX_ENCODERS   (MAX_ENCODERS),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .lane_pos  (lane_pos_next),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .busy      (busy),
        .out_field (out_field)
    );

    assign position_0 = out_field[0];
    assign position_1 = out_field[1];
    assign position_2 = out_field[2];
    assign position_3 = out_field[3];

`ifndef ASSERT_OFF
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid)
        else $error("transfer in gave no result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

    a_history_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(last_phases_reg))
        else $error("phase history changed without a transfer");

    a_idle_lane_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && encoders_reg == '0) |=> $stable(lane_pos[0]))
        else $error("position moved with no encoder in use");

    a_no_move_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_byte[1:0] == last_phases_reg[1:0]) |=> $stable(lane_pos[0]))
        else $error("position moved on an unchanged pair");
`endif

endmodule

>>> hdl/qdec_lane.sv
// One decoder lane: hold-off counter and wrapping position counter of one encoder.
// Depends on qdec_pkg.
module qdec_lane #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  qdec_pkg::lane_ctrl_t               ctrl,
    input  logic [qdec_pkg::LIFE_WIDTH-1:0]    life,
    input  logic [1:0]                         pair_before,
    input  logic [1:0]                         pair_after,
    output logic [POSITION_WIDTH-1:0]          pos,
    output logic [POSITION_WIDTH-1:0]          pos_next
);
    import qdec_pkg::*;

    logic [LIFE_WIDTH-1:0] hold_reg;
    logic [LIFE_WIDTH-1:0] hold_next;
    logic [POSITION_WIDTH-1:0] pos_reg;
    logic [1:0] step;
    logic blocked;

    assign step    = GRAY_RANK[pair_after] - GRAY_RANK[pair_before];
    assign blocked = (pair_after == pair_before) || (hold_reg < life);

    always_comb
    begin
        hold_next = hold_reg;
        pos_next  = pos_reg;
        if (ctrl.decode)
        begin
            if (blocked)
            begin
                hold_next = (hold_reg != '0) ? hold_reg - 1'b1 : life;
            end
            else
            begin
                case (step)
                    STEP_CW:  pos_next = pos_reg + 1'b1;
                    STEP_CCW: pos_next = pos_reg - 1'b1;
                    default:  pos_next = pos_reg;  // no move, or both phases jumped
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
            pos_reg  <= '0;
        end
        else if (ctrl.fire)
        begin
            hold_reg <= hold_next;
            pos_reg  <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

>>> hdl/qdec_merge.sv
// Merge stage: gathers the lane positions into the output register and
// drives the output handshake. Depends on qdec_pkg.
module qdec_merge #(
    parameter int MAX_ENCODERS   = 4,
    parameter int POSITION_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [POSITION_WIDTH-1:0]          lane_pos [MAX_ENCODERS],
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic                               busy,
    output logic [qdec_pkg::FIELD_WIDTH-1:0]   out_field [qdec_pkg::NUM_FIELDS]
);
    import qdec_pkg::*;

    localparam int COPY_WIDTH = (POSITION_WIDTH < FIELD_WIDTH) ? POSITION_WIDTH : FIELD_WIDTH;

    logic out_valid_reg;
    logic out_valid_next;
    logic [FIELD_WIDTH-1:0] field_reg  [NUM_FIELDS];
    logic [FIELD_WIDTH-1:0] field_next [NUM_FIELDS];

    always_comb
    begin
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            if (k < MAX_ENCODERS)
                field_next[k] = FIELD_WIDTH'(lane_pos[k][COPY_WIDTH-1:0]);
            else
                field_next[k] = '0;  // absent channel
        end
    end

    assign busy = out_valid_reg && out_stall;
    assign out_valid_next = load ? 1'b1 : busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            field_reg <= field_next;
    end

    assign out_valid = out_valid_reg;
    assign out_field = field_reg;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_quadrature_decoder: directed table, then random phase streams.
// Depends on qdec_pkg and the decoder RTL; results checked by the table or a local predictor.
module testbench;
    import qdec_pkg::*;

    localparam int MAX_LANES   = 4;
    localparam int STALL_BURST = 40;
    localparam int SEGMENTS    = 6;
    localparam int SEG_ITEMS   = 100;

    typedef logic [NUM_FIELDS-1:0][FIELD_WIDTH-1:0] position_set_t;

    typedef struct {
        bit                         cfg_write;
        logic [CFG_INDEX_WIDTH-1:0] reg_index;
        logic [PHASE_WIDTH-1:0]     value;
        bit                         typed;
        position_set_t              want;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [PHASE_WIDTH-1:0]     phase_byte;
    logic                       out_valid;
    logic                       out_stall;
    logic [FIELD_WIDTH-1:0]     position_0;
    logic [FIELD_WIDTH-1:0]     position_1;
    logic [FIELD_WIDTH-1:0]     position_2;
    logic [FIELD_WIDTH-1:0]     position_3;

    // decoder state as the testbench sees it
    logic [LIFE_WIDTH-1:0]  hold_life = '0;
    logic [COUNT_WIDTH-1:0] lanes_sel = ENCODERS_RESET;
    logic [PHASE_WIDTH-1:0] last_phase = '0;
    logic [LIFE_WIDTH-1:0]  hold_left [MAX_LANES] = '{default: '0};
    logic [FIELD_WIDTH-1:0] pos_count [MAX_LANES] = '{default: '0};

    position_set_t          pending_positions [$];
    stim_row_t              directed_rows [$];
    logic [PHASE_WIDTH-1:0] prev_phases = '0;
    int                     src_idle_pct = 0;
    int                     sink_stall_pct = 0;
    bit                     long_hold = 1'b0;
    int                     mismatches = 0;

    multi_quadrature_decoder #(
        .MAX_ENCODERS   (MAX_LANES),
        .POSITION_WIDTH (FIELD_WIDTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .phase_byte (phase_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position_0 (position_0),
        .position_1 (position_1),
        .position_2 (position_2),
        .position_3 (position_3)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    // place of a {B,A} pair in the clockwise cycle 00 -> 01 -> 11 -> 10
    function automatic logic [1:0] pair_rank(input logic [1:0] pair);
        case (pair)
            2'b00:   return 2'd0;
            2'b01:   return 2'd1;
            2'b11:   return 2'd2;
            default: return 2'd3;
        endcase
    endfunction

    function automatic logic [1:0] rank_pair(input logic [1:0] rank);
        case (rank)
            2'd0:    return 2'b00;
            2'd1:    return 2'b01;
            2'd2:    return 2'b11;
            default: return 2'b10;
        endcase
    endfunction

    task automatic track_encoders(input logic [PHASE_WIDTH-1:0] now,
                                  output position_set_t positions);
        int         lanes;
        logic [1:0] old_pair;
        logic [1:0] new_pair;
        logic [1:0] step;
        lanes = (lanes_sel > MAX_LANES) ? MAX_LANES : int'(lanes_sel);
        for (int k = 0; k < lanes; k++)
        begin
            old_pair = last_phase[2*k +: 2];
            new_pair = now[2*k +: 2];
            if (new_pair == old_pair || hold_left[k] < hold_life)
            begin
                if (hold_left[k] != '0)
                    hold_left[k] = hold_left[k] - 1'b1;
                else
                    hold_left[k] = hold_life;
            end
            else
            begin
                // both bits flipping gives a step of two: ignored
                step = pair_rank(new_pair) - pair_rank(old_pair);
                if (step == STEP_CW)
                    pos_count[k] = pos_count[k] + 1'b1;
                else if (step == STEP_CCW)
                    pos_count[k] = pos_count[k] - 1'b1;
            end
        end
        last_phase = now;
        for (int k = 0; k < NUM_FIELDS; k++)
            positions[k] = (k < MAX_LANES) ? pos_count[k] : '0;
    endtask

    // mostly legal Gray moves per encoder, with an occasional arbitrary byte
    function automatic logic [PHASE_WIDTH-1:0] next_phases(input logic [PHASE_WIDTH-1:0] cur);
        logic [PHASE_WIDTH-1:0] nxt;
        int                     pick;
        if ($urandom_range(0, 9) == 0)
            return PHASE_WIDTH'($urandom_range(0, 255));
        nxt = cur;
        for (int k = 0; k < MAX_LANES; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick >= 7)
                nxt[2*k +: 2] = rank_pair(pair_rank(cur[2*k +: 2]) - 2'd1);
            else if (pick >= 4)
                nxt[2*k +: 2] = rank_pair(pair_rank(cur[2*k +: 2]) + 2'd1);
        end
        return nxt;
    endfunction

    function automatic stim_row_t item_row(input logic [PHASE_WIDTH-1:0] phases);
        stim_row_t row;
        row = '{cfg_write: 1'b0, reg_index: '0, value: phases, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [PHASE_WIDTH-1:0] phases,
                                            input logic [FIELD_WIDTH-1:0] lane_pos);
        stim_row_t row;
        row = '{cfg_write: 1'b0, reg_index: '0, value: phases, typed: 1'b1,
                want: {NUM_FIELDS{lane_pos}}};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                          input logic [CFG_DATA_WIDTH-1:0] data);
        stim_row_t row;
        row = '{cfg_write: 1'b1, reg_index: idx, value: data, typed: 1'b0, want: '0};
        return row;
    endfunction

    // enters and leaves on a falling edge
    task automatic send_phase(input logic [PHASE_WIDTH-1:0] phases, input bit typed,
                              input position_set_t want);
        position_set_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        phase_byte <= phases;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_encoders(phases, predicted);
        pending_positions.push_back(typed ? want : predicted);
        prev_phases = phases;
        @(negedge clk);
    endtask

    // only with nothing in flight; enters and leaves on a falling edge
    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [CFG_DATA_WIDTH-1:0] data);
        in_valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_HOLD_OFF_LIFE:   hold_life = data;
            REG_ENCODERS_IN_USE: lanes_sel = data[COUNT_WIDTH-1:0];
            default: ;  // no such register
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [FIELD_WIDTH-1:0] want,
                                 input logic [FIELD_WIDTH-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected %h got %h", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_positions
        position_set_t got;
        position_set_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {position_3, position_2, position_1, position_0};
            if (pending_positions.size() == 0)
                note_mismatch("unexpected result, position_0", '0, got[0]);
            else
            begin
                want = pending_positions.pop_front();
                for (int k = 0; k < NUM_FIELDS; k++)
                    if (got[k] !== want[k])
                        note_mismatch($sformatf("position_%0d", k), want[k], got[k]);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (STALL_BURST) @(negedge clk);
                long_hold = 1'b0;
            end
            else
                out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    initial
    begin
        logic [LIFE_WIDTH-1:0]  seg_life [SEGMENTS];
        logic [COUNT_WIDTH-1:0] seg_lanes [SEGMENTS];
        stim_row_t              row;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        phase_byte = '0;
        seg_life   = '{8'd0, 8'd3, 8'd255, 8'd1, 8'd0, 8'd7};
        seg_lanes  = '{3'd4, 3'd2, 3'd4, 3'd1, 3'd7, 3'd3};

        // after reset: no hold-off, all four encoders decoded
        directed_rows.push_back(typed_row(8'h00, 16'h0000));
        directed_rows.push_back(typed_row(8'h55, 16'h0001));
        directed_rows.push_back(typed_row(8'hFF, 16'h0002));
        directed_rows.push_back(typed_row(8'hAA, 16'h0003));
        directed_rows.push_back(typed_row(8'h00, 16'h0004));
        directed_rows.push_back(typed_row(8'hAA, 16'h0003));
        directed_rows.push_back(item_row(8'hFF));
        directed_rows.push_back(item_row(8'h55));
        directed_rows.push_back(item_row(8'h00));
        directed_rows.push_back(typed_row(8'hAA, 16'hFFFF));  // wrap below zero
        directed_rows.push_back(typed_row(8'h00, 16'h0000));  // wrap back up
        directed_rows.push_back(typed_row(8'hFF, 16'h0000));  // both phases flip
        directed_rows.push_back(item_row(8'h1B));             // mixed moves per lane
        directed_rows.push_back(cfg_row(REG_ENCODERS_IN_USE, 8'd0));
        directed_rows.push_back(item_row(8'hE4));
        directed_rows.push_back(cfg_row(REG_ENCODERS_IN_USE, 8'd7));
        directed_rows.push_back(item_row(8'h00));
        directed_rows.push_back(cfg_row(REG_ENCODERS_IN_USE, 8'd1));
        directed_rows.push_back(item_row(8'h55));
        directed_rows.push_back(cfg_row(REG_HOLD_OFF_LIFE, 8'd255));
        directed_rows.push_back(item_row(8'h54));
        directed_rows.push_back(item_row(8'h55));
        directed_rows.push_back(cfg_row(2'd2, 8'h5A));        // unused index
        directed_rows.push_back(cfg_row(2'd3, 8'hFF));
        directed_rows.push_back(cfg_row(REG_HOLD_OFF_LIFE, 8'd2));
        directed_rows.push_back(cfg_row(REG_ENCODERS_IN_USE, 8'd4));
        directed_rows.push_back(item_row(8'hFF));
        directed_rows.push_back(item_row(8'hAA));
        directed_rows.push_back(item_row(8'hAA));
        directed_rows.push_back(item_row(8'h00));
        directed_rows.push_back(item_row(8'h55));
        directed_rows.push_back(item_row(8'hFF));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct   = 12;
        sink_stall_pct = 71;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.cfg_write)
                write_register(row.reg_index, row.value);
            else
                send_phase(row.value, row.typed, row.want);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 2)
            begin
                src_idle_pct   = 71;
                sink_stall_pct = 12;
            end
            else if (seg == 4)
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            write_register(REG_HOLD_OFF_LIFE, seg_life[seg]);
            write_register(REG_ENCODERS_IN_USE, CFG_DATA_WIDTH'(seg_lanes[seg]));
            // back the pipe up while the sender keeps offering transfers
            if (seg == 4)
                long_hold = 1'b1;
            for (int n = 0; n < SEG_ITEMS; n++)
                send_phase(next_phases(prev_phases), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_positions.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
